FILE: hw/rtl/tcl_pkg.sv
// Package for the two-way cache tag lookup: sizes, the set row layout and
// the command/status structs shared by the controller and the datapath.
// Depends on nothing.
package tcl_pkg;

  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned TAG_LSB     = 16;
  localparam int unsigned SET_FIELD_W = 14;
  localparam int unsigned SET_LSB     = 2;

  // Number of sets, 2 to 16384.
  localparam int unsigned SET_COUNT = 16384;
  localparam int unsigned SET_BITS  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam bit          SET_POW2  = (SET_COUNT == (1 << SET_BITS));

  // Reciprocal used to reduce the set field modulo SET_COUNT.
  localparam int unsigned RECIP_SHIFT = 2 * SET_FIELD_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT;
  localparam int unsigned RECIP       = (32'd1 << RECIP_SHIFT) / SET_COUNT;

  // One set: LRU bit, both valid bits and both tags.
  typedef struct packed {
    logic                victim;
    logic                valid1;
    logic                valid0;
    logic [TAG_BITS-1:0] tag1;
    logic [TAG_BITS-1:0] tag0;
  } tcl_row_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic mul;
    logic red;
    logic upd;
  } tcl_cmd_t;

  typedef struct packed {
    logic clr_last;
  } tcl_sts_t;

endpackage

FILE: hw/rtl/tcl_dp.sv
// Datapath of the two-way cache tag lookup: set row memory, index
// reduction, tag compare, LRU update, counters and output registers.
// Depends on tcl_pkg.
module tcl_dp
  import tcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tcl_cmd_t          cmd,
  output tcl_sts_t          sts,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_hit,
  output logic              out_way_used,
  output logic [CNT_W-1:0]  out_hit_total,
  output logic [CNT_W-1:0]  out_miss_total
);

  localparam int unsigned PROD_W = SET_FIELD_W + RECIP_W;
  localparam int unsigned QN_W   = 2 * SET_FIELD_W + 1;
  localparam logic [RECIP_W-1:0]   RECIP_C = RECIP_W'(RECIP);
  localparam logic [SET_FIELD_W:0] NC      = (SET_FIELD_W + 1)'(SET_COUNT);

  tcl_row_t mem [SET_COUNT];

  logic [SET_FIELD_W-1:0] fld_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic [SET_FIELD_W-1:0] q_r;
  logic [SET_BITS-1:0]    set_r;
  logic [SET_BITS-1:0]    clr_cnt_r;
  tcl_row_t               rdata_r;
  logic [CNT_W-1:0]       hit_cnt_r;
  logic [CNT_W-1:0]       miss_cnt_r;
  logic [CNT_W-1:0]       hit_cnt_nxt;
  logic [CNT_W-1:0]       miss_cnt_nxt;
  logic                   out_hit_r;
  logic                   out_way_r;
  logic [CNT_W-1:0]       out_hit_total_r;
  logic [CNT_W-1:0]       out_miss_total_r;

  logic [PROD_W-1:0]      prod;
  logic [QN_W-1:0]        qn;
  logic [SET_FIELD_W:0]   diff;
  logic [SET_FIELD_W:0]   red;
  logic [SET_BITS-1:0]    set_red;
  logic [SET_BITS-1:0]    set_in;
  logic                   rd_en;
  logic [SET_BITS-1:0]    rd_set;
  logic                   wr_en;
  logic [SET_BITS-1:0]    wr_set;
  tcl_row_t               wr_row;
  tcl_row_t               upd_row;
  logic                   match0;
  logic                   match1;
  logic                   hit;
  logic                   way;

  // Index reduction: quotient estimate, then one remainder correction.
  assign prod    = {{SET_FIELD_W{1'b0}}, RECIP_C} * {{RECIP_W{1'b0}}, fld_r};
  assign qn      = QN_W'(q_r) * QN_W'(NC);
  assign diff    = {1'b0, fld_r} - qn[SET_FIELD_W:0];
  assign red     = (diff >= NC) ? (diff - NC) : diff;
  assign set_red = red[SET_BITS-1:0];
  assign set_in  = in_address[SET_LSB +: SET_BITS];

  assign rd_en  = (cmd.load && SET_POW2) || cmd.red;
  assign rd_set = cmd.red ? set_red : set_in;

  // Compare and replacement.
  always_comb begin
    match0  = rdata_r.valid0 && (rdata_r.tag0 == tag_r);
    match1  = rdata_r.valid1 && (rdata_r.tag1 == tag_r);
    hit     = match0 || match1;
    way     = match0 ? 1'b0 : (match1 ? 1'b1 : rdata_r.victim);
    upd_row = rdata_r;
    if (!hit) begin
      if (way) begin
        upd_row.tag1   = tag_r;
        upd_row.valid1 = 1'b1;
      end else begin
        upd_row.tag0   = tag_r;
        upd_row.valid0 = 1'b1;
      end
    end
    upd_row.victim = ~way;
    hit_cnt_nxt    = hit ? (hit_cnt_r + 1'b1) : hit_cnt_r;
    miss_cnt_nxt   = hit ? miss_cnt_r : (miss_cnt_r + 1'b1);
  end

  assign wr_en  = cmd.clr || cmd.upd;
  assign wr_set = cmd.clr ? clr_cnt_r : set_r;
  assign wr_row = cmd.clr ? tcl_row_t'('0) : upd_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_set] <= wr_row;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_set];
      set_r   <= rd_set;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      fld_r <= in_address[SET_LSB +: SET_FIELD_W];
      tag_r <= in_address[TAG_LSB +: TAG_BITS];
    end
    if (cmd.mul) begin
      q_r <= prod[RECIP_SHIFT +: SET_FIELD_W];
    end
    if (cmd.upd) begin
      out_hit_r        <= hit;
      out_way_r        <= way;
      out_hit_total_r  <= hit_cnt_nxt;
      out_miss_total_r <= miss_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r  <= '0;
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.upd) begin
        hit_cnt_r  <= hit_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
      end
    end
  end

  assign sts.clr_last   = (clr_cnt_r == SET_BITS'(SET_COUNT - 1));
  assign out_hit        = out_hit_r;
  assign out_way_used   = out_way_r;
  assign out_hit_total  = out_hit_total_r;
  assign out_miss_total = out_miss_total_r;

endmodule

FILE: hw/rtl/tcl_ctrl.sv
// Controller of the two-way cache tag lookup: clearing pass, request
// sequencing and the output valid flag.
// Depends on tcl_pkg.
module tcl_ctrl
  import tcl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output tcl_cmd_t cmd,
  input  tcl_sts_t sts
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_RED   = 3'd3;
  localparam logic [2:0] ST_LOOK  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = SET_POW2 ? ST_LOOK : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.red   = 1'b1;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (out_free) begin
          cmd.upd   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid_nxt = cmd.upd || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but next request not held off");

  a_upd_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> out_valid)
    else $error("lookup finished without a result presented");

  a_upd_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> (!out_valid_r || !out_stall))
    else $error("result overwrote an undelivered result");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr, cmd.load, cmd.mul, cmd.red, cmd.upd}))
    else $error("more than one datapath command at once");
`endif

endmodule

FILE: hw/rtl/two_way_cache_tag_lookup_lru.sv
// Top level of the two-way set-associative cache tag lookup with LRU.
// Instantiates tcl_ctrl and tcl_dp; depends on tcl_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    in_address
//   out_     output     out_valid/out_stall  out_hit, out_way_used,
//                                            out_hit_total, out_miss_total
//
// With the default power-of-two set count, the accept edge reads the set row;
// in the lookup state, once the output register is free, the row is compared
// and written back and the output register is loaded. Other set counts first
// pass through a reciprocal multiply state and a reduction state, which reduce
// the index and read the row. After reset a clearing pass writes every set row
// (SET_COUNT rows, 16384 by default) with in_stall high.
// One new request is accepted while a result waits in the output register;
// the lookup then holds until that result is taken.
module two_way_cache_tag_lookup_lru
  import tcl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic              out_way_used,
  output logic [CNT_W-1:0]  out_hit_total,
  output logic [CNT_W-1:0]  out_miss_total
);

  // Commands from the controller to the datapath, status back.
  tcl_cmd_t cmd;
  tcl_sts_t sts;

  // The controller sequences each request and owns both handshakes.
  tcl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath holds the set rows, the counters and the result payload.
  tcl_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_address     (in_address),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_way_cache_tag_lookup_lru: directed and random lookups,
// checked against a behavioral two-way LRU tag store kept alongside the block.
// Depends on tcl_pkg and the two_way_cache_tag_lookup_lru RTL.
module testbench;
  import tcl_pkg::*;

  // One lookup result, in the order the block reports its fields.
  typedef struct packed {
    logic             hit;
    logic             way_used;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
  } lookup_result_t;

  // One row of the directed table. Where typed is set, the result column is
  // the expectation. Elsewhere the tag store model decides.
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    bit                typed;
    lookup_result_t    result;
  } directed_row_t;

  localparam int unsigned DIRECTED_ROWS = 22;
  localparam int unsigned RANDOM_ITEMS  = 1528;
  localparam int unsigned HOT_SETS      = 6;
  localparam int unsigned HOT_TAGS      = 4;
  // The receiver stops taking results for a long stretch once this many
  // requests have gone in, so that the block backs up into its input.
  localparam int unsigned HOLD_AT       = 300;
  localparam int unsigned HOLD_CYCLES   = 80;
  // The random request at this index waits until the block has drained.
  localparam int unsigned DRAIN_AT      = 450;
  // Random requests in this range run with no idling on either side.
  localparam int unsigned CALM_FIRST    = 700;
  localparam int unsigned CALM_LAST     = 999;
  localparam int unsigned MAX_REPORTS   = 10;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic              out_stall;
  logic              out_hit;
  logic              out_way_used;
  logic [CNT_W-1:0]  out_hit_total;
  logic [CNT_W-1:0]  out_miss_total;

  // Tag store model: per-set tags, valid bits and the LRU victim bit, plus
  // the two running counters. Everything starts at zero, which is the reset
  // state of the valid bits, the victim bits and the counters. The zero in
  // the tags never shows, since a tag only counts together with its valid bit.
  bit [TAG_BITS-1:0] way0_tag   [SET_COUNT];
  bit [TAG_BITS-1:0] way1_tag   [SET_COUNT];
  bit                way0_valid [SET_COUNT];
  bit                way1_valid [SET_COUNT];
  bit                lru_victim [SET_COUNT];
  bit [CNT_W-1:0]    hit_count;
  bit [CNT_W-1:0]    miss_count;

  lookup_result_t expected_lookups [$];
  int unsigned    accepted_count;
  int unsigned    mismatch_count;
  bit             calm;

  logic [SET_FIELD_W-1:0] hot_sets [HOT_SETS];
  logic [TAG_BITS-1:0]    hot_tags [HOT_TAGS];

  // Set 0 is run through fill, hit, second fill and eviction in both orders.
  // After that come the all-ones set and tag, the two alternating bit
  // patterns, and a three-tag rotation on set 1 that keeps evicting.
  // Only the opening rows on a fresh set have their results typed in.
  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd1}},  // cold miss fills way 0
    '{32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'd1, 32'd1}},  // hit on way 0
    '{32'hFFFF_0000, 1'b1, '{1'b0, 1'b1, 32'd1, 32'd2}},  // second tag fills way 1
    '{32'hFFFF_0003, 1'b1, '{1'b1, 1'b1, 32'd2, 32'd2}},  // byte offset is ignored
    '{32'h0000_0000, 1'b0, '0},
    '{32'h1234_0000, 1'b0, '0},
    '{32'hFFFF_0000, 1'b0, '0},
    '{32'h1234_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'hFFFF_FFFC, 1'b0, '0},
    '{32'h0000_FFFF, 1'b0, '0},
    '{32'h0000_FFFD, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h5555_5555, 1'b0, '0},
    '{32'h0001_0004, 1'b0, '0},
    '{32'h0002_0004, 1'b0, '0},
    '{32'h0001_0004, 1'b0, '0},
    '{32'h0003_0004, 1'b0, '0},
    '{32'h0002_0004, 1'b0, '0},
    '{32'h0001_0004, 1'b0, '0}
  };

  two_way_cache_tag_lookup_lru DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_way_used   (out_way_used),
    .out_hit_total  (out_hit_total),
    .out_miss_total (out_miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Looks one address up in the tag store model and updates it the way the
  // block does: a hit refreshes the hitting way, and a miss fills the LRU way.
  // Either way, the other way becomes the next victim.
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    int unsigned         set_idx;
    logic [TAG_BITS-1:0] tag;
    logic                match0;
    logic                match1;
    lookup_result_t      r;
    // A set count below 2^14 folds the set field back onto the real sets.
    set_idx = addr[SET_LSB +: SET_FIELD_W] % SET_COUNT;
    tag     = addr[TAG_LSB +: TAG_BITS];
    match0  = way0_valid[set_idx] && (way0_tag[set_idx] == tag);
    match1  = way1_valid[set_idx] && (way1_tag[set_idx] == tag);
    if (match0) begin
      // Way 0 wins if both ways ever matched.
      r.hit      = 1'b1;
      r.way_used = 1'b0;
    end else if (match1) begin
      r.hit      = 1'b1;
      r.way_used = 1'b1;
    end else begin
      r.hit      = 1'b0;
      r.way_used = lru_victim[set_idx];
      if (r.way_used) begin
        way1_tag[set_idx]   = tag;
        way1_valid[set_idx] = 1'b1;
      end else begin
        way0_tag[set_idx]   = tag;
        way0_valid[set_idx] = 1'b1;
      end
    end
    lru_victim[set_idx] = ~r.way_used;
    // Both counters wrap silently at 2^32.
    if (r.hit) hit_count++;
    else miss_count++;
    r.hit_total  = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  // Idle cycles before the next request: about one request in six is
  // delayed, except in the calm stretch.
  function automatic int unsigned idle_gap();
    if (!calm && $urandom_range(0, 99) < 16) return $urandom_range(1, 4);
    return 0;
  endfunction

  // Offers one request, holding it steady until the block takes it. The
  // expectation is queued at the accepting edge. Its result cannot come
  // out before the next edge, so the monitor never misses it.
  task automatic offer_request(input logic [ADDR_W-1:0] addr, input int unsigned gap,
                               input bit typed, input lookup_result_t typed_result);
    lookup_result_t predicted;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = predict_lookup(addr);
    expected_lookups.push_back(typed ? typed_result : predicted);
    accepted_count++;
  endtask

  // Request side: reset, the directed table, then random requests. Most of
  // these go to a handful of hot sets with a handful of hot tags, so hits,
  // LRU refreshes, evictions and back-to-back accesses to one set are common.
  // The rest use fresh tags in hot sets or fully random addresses.
  initial begin
    logic [ADDR_W-1:0] addr;
    int unsigned       roll;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_address <= '0;
    calm       = 1'b0;
    for (int i = 0; i < HOT_SETS; i++) begin
      hot_sets[i] = SET_FIELD_W'($urandom_range(0, (1 << SET_FIELD_W) - 1));
    end
    for (int i = 0; i < HOT_TAGS; i++) begin
      hot_tags[i] = TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // The first request waits out the clearing pass behind in_stall.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_request(directed_rows[i].address, idle_gap(), directed_rows[i].typed,
                    directed_rows[i].result);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= CALM_FIRST) && (i <= CALM_LAST);
      if (i == DRAIN_AT) begin
        // Let the block run completely dry before going on.
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_lookups.size() != 0);
      end
      addr = $urandom;
      roll = $urandom_range(0, 99);
      if (roll < 85) addr[SET_LSB +: SET_FIELD_W] = hot_sets[$urandom_range(0, HOT_SETS - 1)];
      if (roll < 70) addr[TAG_LSB +: TAG_BITS] = hot_tags[$urandom_range(0, HOT_TAGS - 1)];
      offer_request(addr, idle_gap(), 1'b0, '0);
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    // Idle on to catch any result that should not be there.
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_lookups.size() == 0) begin
      $display("two_way_cache_tag_lookup_lru: match");
    end else begin
      $display("two_way_cache_tag_lookup_lru: mismatch");
    end
    $finish;
  end

  // Result side: random stalls, none in the calm stretch, and one long
  // hold-off that fills the block while requests keep coming.
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    out_stall <= 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 16);
      end
    end
  end

  // Every result taken is compared with the oldest outstanding expectation.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_lookups.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: result with no request outstanding: %s %b way %b hits %0d misses %0d",
                   $realtime, "hit", out_hit, out_way_used, out_hit_total, out_miss_total);
        end
      end else begin
        want = expected_lookups.pop_front();
        if (out_hit !== want.hit || out_way_used !== want.way_used ||
            out_hit_total !== want.hit_total || out_miss_total !== want.miss_total) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected hit %b way %b hits %0d misses %0d,",
                     $realtime, want.hit, want.way_used, want.hit_total, want.miss_total);
            $display("    got hit %b way %b hits %0d misses %0d",
                     out_hit, out_way_used, out_hit_total, out_miss_total);
          end
        end
      end
    end
  end

  // Hard limit, several times the slowest legal run including the clearing
  // pass after reset.
  initial begin
    #5_000_000;
    $display("two_way_cache_tag_lookup_lru: mismatch");
    $finish;
  end

endmodule
